FILE: design/assert_macros.svh
// Assertion helpers used by sha256_stream_hasher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is checked at every rising clock edge and is
// switched off while the active-low reset is asserted.
`define SHA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Concurrent assertion that is checked at every rising clock edge, during reset too.
`define SHA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/sha_pkg.sv
package sha_pkg;

  typedef logic [31:0] word_t;
  typedef word_t hash_t [8];

  localparam int ROUNDS      = 64;
  localparam int BLOCK_BYTES = 64;
  localparam int LEN_POS     = 56;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMP,
    S_FIN,
    S_PAD
  } state_e;

  // Control from the sequencer to the message window and the round unit.
  typedef struct packed {
    logic byte_en;   // shift one byte into the message window
    logic load;      // load the working variables from the chaining value
    logic round_en;  // run one compression round
    logic fin_keep;  // add the working variables into the chaining value
    logic fin_init;  // return the chaining value to the initial hash
  } ctrl_t;

  localparam hash_t IV = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t K_TABLE [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

FILE: design/sha_sched.sv
// Message window: sixteen words that collect the block byte by byte and
// then slide one word per round while producing the expanded schedule.
module sha_sched (
  input  logic           clk_i,
  input  sha_pkg::ctrl_t ctrl_i,
  input  logic [7:0]     byte_i,
  output sha_pkg::word_t w_o
);

  // win_q[15] holds the oldest word (W[t]), win_q[0] the newest.
  sha_pkg::word_t win_q [16];
  sha_pkg::word_t win_d [16];
  sha_pkg::word_t w_new;

  assign w_new = sha_pkg::small_sigma1(win_q[1]) + win_q[6] +
                 sha_pkg::small_sigma0(win_q[14]) + win_q[15];

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      win_d[i] = win_q[i];
    end
    if (ctrl_i.byte_en) begin
      for (int i = 15; i > 0; i--) begin
        win_d[i] = {win_q[i][23:0], win_q[i-1][31:24]};
      end
      win_d[0] = {win_q[0][23:0], byte_i};
    end else if (ctrl_i.round_en) begin
      for (int i = 15; i > 0; i--) begin
        win_d[i] = win_q[i-1];
      end
      win_d[0] = w_new;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  assign w_o = win_q[15];

endmodule

FILE: design/sha_round.sv
// Compression round unit and chaining value. One round per enabled cycle.
module sha_round (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sha_pkg::ctrl_t ctrl_i,
  input  logic [5:0]     round_i,
  input  sha_pkg::word_t w_i,
  output sha_pkg::hash_t sum_o
);

  sha_pkg::hash_t h_q;
  sha_pkg::hash_t v_q;
  sha_pkg::hash_t v_d;
  sha_pkg::word_t t1;
  sha_pkg::word_t t2;

  assign t1 = v_q[7] + sha_pkg::big_sigma1(v_q[4]) +
              ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) +
              sha_pkg::K_TABLE[round_i] + w_i;
  assign t2 = sha_pkg::big_sigma0(v_q[0]) +
              ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  always_comb begin
    v_d = v_q;
    if (ctrl_i.load) begin
      v_d = h_q;
    end else if (ctrl_i.round_en) begin
      v_d[7] = v_q[6];
      v_d[6] = v_q[5];
      v_d[5] = v_q[4];
      v_d[4] = v_q[3] + t1;
      v_d[3] = v_q[2];
      v_d[2] = v_q[1];
      v_d[1] = v_q[0];
      v_d[0] = t1 + t2;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      sum_o[i] = h_q[i] + v_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= sha_pkg::IV;
    end else if (ctrl_i.fin_init) begin
      h_q <= sha_pkg::IV;
    end else if (ctrl_i.fin_keep) begin
      h_q <= sum_o;
    end
  end

endmodule

FILE: design/sha256_stream_hasher.sv
// SHA-256 streaming hasher, one message byte per request.
// Input channel: in_valid_i with in_stall_o; a request carries message_byte_i,
// byte_present_i and end_of_message_i. A request without byte and without end
// mark changes nothing. Output channel: out_valid_o with out_stall_i; each
// request carries one digest word, its word number and a final-word flag.
// Byte requests are taken one per cycle while the sequencer is idle. The 64th
// byte of a block starts the compression, which runs one round per cycle on a
// single shared round unit and is followed by a fold of the result into the
// chaining value. An end mark shifts padding and length bytes one per cycle
// and runs one or two compressions; the digest is then copied into an output
// buffer, once that buffer is free, and leaves as eight requests, word 0 first.
// The input side is stalled whenever the sequencer is busy; a stalled output
// holds its word, and a following message may be taken meanwhile, only its
// own digest hand-over waits until the buffer is drained.
// Reset returns the chaining value to the initial hash values and empties the
// buffer and the length; no clearing pass is needed.
`include "assert_macros.svh"

module sha256_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  message_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_number_o,
  output logic        final_word_o
);

  localparam logic [5:0] LastRound = 6'(sha_pkg::ROUNDS - 1);
  localparam logic [6:0] LastByte  = 7'(sha_pkg::BLOCK_BYTES - 1);
  localparam logic [6:0] LenPos    = 7'(sha_pkg::LEN_POS);

  sha_pkg::state_e state_q, state_d;
  sha_pkg::ctrl_t  ctrl;

  logic [5:0]  rnd_q, rnd_d;
  logic [6:0]  fill_q, fill_d;
  logic [60:0] len_q, len_d;
  // pad_q: the current message is being closed. first_q: the 0x80 byte is
  // still to come. final_blk_q: the block being filled carries the length.
  logic        pad_q, pad_d;
  logic        first_q, first_d;
  logic        final_blk_q, final_blk_d;

  logic           in_accept;
  logic           digest_load;
  logic [7:0]     shift_byte;
  logic [63:0]    len_sh;
  sha_pkg::word_t w;
  sha_pkg::hash_t sum;

  // Output buffer: holds a finished digest while it drains.
  sha_pkg::hash_t out_buf_q;
  logic           out_valid_q;
  logic [2:0]     out_cnt_q;
  logic           out_accept;

  assign in_stall_o = (state_q != sha_pkg::S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_q && !out_stall_i;

  // Big-endian length byte for the position fill_q within the last eight
  // bytes of the block: position 56 takes the most significant byte.
  assign len_sh = {len_q, 3'b000} << {fill_q[2:0], 3'b000};

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sha_pkg::S_IDLE: begin
        if (in_accept) begin
          if (byte_present_i && fill_q == LastByte) begin
            state_d = sha_pkg::S_COMP;
          end else if (end_of_message_i) begin
            state_d = sha_pkg::S_PAD;
          end
        end
      end
      sha_pkg::S_COMP: begin
        if (rnd_q == LastRound) begin
          state_d = sha_pkg::S_FIN;
        end
      end
      sha_pkg::S_FIN: begin
        if (pad_q && final_blk_q) begin
          // The digest waits here until the previous one has drained.
          if (!out_valid_q) begin
            state_d = sha_pkg::S_IDLE;
          end
        end else if (pad_q) begin
          state_d = sha_pkg::S_PAD;
        end else begin
          state_d = sha_pkg::S_IDLE;
        end
      end
      sha_pkg::S_PAD: begin
        if (fill_q == LastByte) begin
          state_d = sha_pkg::S_COMP;
        end
      end
      default: state_d = sha_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer: control and next values of its counters.
  always_comb begin
    ctrl        = '0;
    digest_load = 1'b0;
    shift_byte  = message_byte_i;
    rnd_d       = rnd_q;
    fill_d      = fill_q;
    len_d       = len_q;
    pad_d       = pad_q;
    first_d     = first_q;
    final_blk_d = final_blk_q;
    unique case (state_q)
      sha_pkg::S_IDLE: begin
        if (in_accept) begin
          if (byte_present_i) begin
            ctrl.byte_en = 1'b1;
            fill_d       = fill_q + 7'd1;
            len_d        = len_q + 61'd1;
          end
          if (end_of_message_i) begin
            pad_d       = 1'b1;
            first_d     = 1'b1;
            final_blk_d = 1'b0;
          end
          if (byte_present_i && fill_q == LastByte) begin
            // The block is full: the window is consumed by the rounds.
            ctrl.load = 1'b1;
            rnd_d     = '0;
            fill_d    = '0;
          end
        end
      end
      sha_pkg::S_COMP: begin
        ctrl.round_en = 1'b1;
        rnd_d         = rnd_q + 6'd1;
      end
      sha_pkg::S_FIN: begin
        if (pad_q && final_blk_q) begin
          if (!out_valid_q) begin
            digest_load   = 1'b1;
            ctrl.fin_init = 1'b1;
            fill_d        = '0;
            len_d         = '0;
            pad_d         = 1'b0;
          end
        end else begin
          ctrl.fin_keep = 1'b1;
          // The 0x80 byte went into the block just compressed, so the
          // next block is the one that carries the length.
          if (pad_q && !first_q) begin
            final_blk_d = 1'b1;
          end
        end
      end
      sha_pkg::S_PAD: begin
        ctrl.byte_en = 1'b1;
        fill_d       = fill_q + 7'd1;
        if (first_q) begin
          shift_byte  = sha_pkg::PAD_BYTE;
          first_d     = 1'b0;
          final_blk_d = (fill_q < LenPos);
        end else if (final_blk_q && fill_q >= LenPos) begin
          shift_byte = len_sh[63:56];
        end else begin
          shift_byte = 8'h00;
        end
        if (fill_q == LastByte) begin
          ctrl.load = 1'b1;
          rnd_d     = '0;
          fill_d    = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sha_pkg::S_IDLE;
      rnd_q       <= '0;
      fill_q      <= '0;
      len_q       <= '0;
      pad_q       <= 1'b0;
      first_q     <= 1'b0;
      final_blk_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      fill_q      <= fill_d;
      len_q       <= len_d;
      pad_q       <= pad_d;
      first_q     <= first_d;
      final_blk_q <= final_blk_d;
    end
  end

  sha_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .byte_i (shift_byte),
    .w_o    (w)
  );

  sha_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .round_i (rnd_q),
    .w_i     (w),
    .sum_o   (sum)
  );

  // Output side: the digest buffer drains one word per accepted request.
  always_ff @(posedge clk_i) begin
    if (digest_load) begin
      out_buf_q <= sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_cnt_q   <= '0;
    end else if (digest_load) begin
      out_valid_q <= 1'b1;
      out_cnt_q   <= '0;
    end else if (out_accept) begin
      if (&out_cnt_q) begin
        out_valid_q <= 1'b0;
      end
      out_cnt_q <= out_cnt_q + 3'd1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign digest_word_o = out_buf_q[out_cnt_q];
  assign word_number_o = out_cnt_q;
  assign final_word_o  = &out_cnt_q;

  // A new digest is never copied over one that is still draining.
  `SHA_ASSERT(a_no_overwrite, clk_i, rst_ni, digest_load |-> !out_valid_q,
              "digest loaded while output buffer busy")
  // Taking the eighth word empties the buffer.
  `SHA_ASSERT(a_drain_done, clk_i, rst_ni, (out_accept && final_word_o) |=> !out_valid_o,
              "output still valid after final word")
  // The fold cycle follows the last round.
  `SHA_ASSERT(a_fin_after_rounds, clk_i, rst_ni,
              (state_q == sha_pkg::S_COMP && rnd_q == LastRound) |=> (state_q == sha_pkg::S_FIN),
              "fold not reached after the last round")
  // While idle, the message window never holds a complete, uncompressed block.
  `SHA_ASSERT(a_fill_range, clk_i, rst_ni, (state_q == sha_pkg::S_IDLE) |-> (fill_q < 7'd64),
              "fill count out of range while idle")

endmodule
